// File: sv/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types and constants for the two-class oldest-first FIFO.
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam int TCF_QUEUE_DEPTH = 16;
    localparam int PAYLOAD_BITS    = 16;
    localparam int STAMP_BITS      = 16;
    localparam int SLOT_BITS       = PAYLOAD_BITS + STAMP_BITS;

    typedef enum logic [1:0] {
        MODE_ENQ     = 2'd0,
        MODE_DEQ_ANY = 2'd1,
        MODE_DEQ_C0  = 2'd2,
        MODE_DEQ_C1  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_mode                   mode;
        logic                    item_class;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_in;

    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] out_payload;
        logic                    out_class;
        logic [STAMP_BITS-1:0]   out_stamp;
        t_status                 status;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_EXEC = 2'd2,
        S_OUT  = 2'd3
    } t_state;

    typedef struct packed {
        logic load_in;
        logic read;
        logic exec;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// File: sv/tcf_ram.sv
// ----------------------------------------------------------------------------
// tcf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/tcf_ctrl.sv
// ----------------------------------------------------------------------------
// tcf_ctrl
// Sequencer: accept, head read, queue update, result hand-off.
// ----------------------------------------------------------------------------
module tcf_ctrl
    import tcf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: n_state = S_OUT;
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_in  = i_in_valid;
            end
            S_READ: o_cmd.read = 1'b1;
            S_EXEC: o_cmd.exec = 1'b1;
            S_OUT:  o_cmd.load_out = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: sv/tcf_dp.sv
// ----------------------------------------------------------------------------
// tcf_dp
// Datapath: class stores, ring pointers, arrival stamp, output register.
// ----------------------------------------------------------------------------
module tcf_dp
    import tcf_pkg::*;
#(
    parameter int QUEUE_DEPTH = TCF_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_in  i_in,
    input  logic i_out_ready,
    output t_sts o_sts,
    output logic o_out_valid,
    output t_out o_out
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    t_in                   r_op;
    t_out                  r_res;
    t_out                  n_res;
    t_out                  r_out;
    logic                  r_out_valid;
    logic [PTR_W-1:0]      r_head [2];
    logic [PTR_W-1:0]      n_head [2];
    logic [PTR_W-1:0]      r_tail [2];
    logic [PTR_W-1:0]      n_tail [2];
    logic [CNT_W-1:0]      r_cnt  [2];
    logic [CNT_W-1:0]      n_cnt  [2];
    logic [STAMP_BITS-1:0] r_ctr;
    logic [STAMP_BITS-1:0] n_ctr;

    logic [1:0]            w_we;
    logic [SLOT_BITS-1:0]  w_rd [2];
    logic [STAMP_BITS-1:0] w_diff;
    logic                  w_sel;
    logic                  w_full;
    logic                  w_cls;

    genvar g;
    generate
        for (g = 0; g < 2; g++) begin : g_store
            tcf_ram #(
                .WIDTH (SLOT_BITS),
                .DEPTH (QUEUE_DEPTH)
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (w_we[g]),
                .i_waddr (r_tail[g]),
                .i_wdata ({r_op.payload, r_ctr}),
                .i_re    (i_cmd.read),
                .i_raddr (r_head[g]),
                .o_rdata (w_rd[g])
            );
        end
    endgenerate

    assign w_cls  = r_op.item_class;
    assign w_diff = w_rd[0][STAMP_BITS-1:0] - w_rd[1][STAMP_BITS-1:0];
    assign w_full = (r_cnt[w_cls] == CNT_W'(QUEUE_DEPTH));

    always_comb begin
        case (r_op.mode)
            MODE_DEQ_C0:  w_sel = 1'b0;
            MODE_DEQ_C1:  w_sel = 1'b1;
            MODE_DEQ_ANY: begin
                if (r_cnt[0] == '0) begin
                    w_sel = 1'b1;
                end else if (r_cnt[1] == '0) begin
                    w_sel = 1'b0;
                end else begin
                    w_sel = ~w_diff[STAMP_BITS-1];
                end
            end
            default: w_sel = w_cls;
        endcase
    end

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_cnt  = r_cnt;
        n_ctr  = r_ctr;
        n_res  = r_res;
        w_we   = '0;
        if (i_cmd.exec) begin
            if (r_op.mode == MODE_ENQ) begin
                n_res.out_payload = '0;
                n_res.out_class   = w_cls;
                n_res.out_stamp   = r_ctr;
                if (w_full) begin
                    n_res.status = ST_FULL;
                end else begin
                    n_res.status  = ST_OK;
                    w_we[w_cls]   = 1'b1;
                    n_tail[w_cls] = f_next(r_tail[w_cls]);
                    n_cnt[w_cls]  = r_cnt[w_cls] + 1'b1;
                    n_ctr         = r_ctr + 1'b1;
                end
            end else if (r_cnt[w_sel] == '0) begin
                n_res.out_payload = '0;
                n_res.out_class   = 1'b0;
                n_res.out_stamp   = '0;
                n_res.status      = ST_EMPTY;
            end else begin
                n_res.out_payload = w_rd[w_sel][STAMP_BITS +: PAYLOAD_BITS];
                n_res.out_class   = w_sel;
                n_res.out_stamp   = w_rd[w_sel][STAMP_BITS-1:0];
                n_res.status      = ST_OK;
                n_head[w_sel]     = f_next(r_head[w_sel]);
                n_cnt[w_sel]      = r_cnt[w_sel] - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '{default: '0};
            r_tail      <= '{default: '0};
            r_cnt       <= '{default: '0};
            r_ctr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
            r_ctr  <= n_ctr;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op <= i_in;
        end
        r_res <= n_res;
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out          = r_out;

endmodule

// File: sv/two_class_fifo_oldest_first.sv
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first
// Two class FIFOs sharing one arrival stamp; oldest-first or per-class pop.
// ----------------------------------------------------------------------------
// One transaction at a time: an accepted item walks the sequencer steps
// accept / head read / queue update / output load, and the next item is taken
// only once its result is in the output register. The head read is a step of
// its own because the class stores have registered read ports. A finished
// result may wait in the output register while the next item is accepted and
// processed; that item stalls only at output load.
// ----------------------------------------------------------------------------
module two_class_fifo_oldest_first
    import tcf_pkg::*;
#(
    parameter int QUEUE_DEPTH = TCF_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    t_cmd w_cmd;
    t_sts w_sts;

    tcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    tcf_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

`ifndef SYNTH
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load_in, w_cmd.read, w_cmd.exec, w_cmd.load_out}))
        else $error("more than one sequencer command active");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("new transaction taken while one is in flight");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("pending result overwritten");
`endif

endmodule
